@@ rtl/core/rcwi_pkg.sv @@
// Shared widths, register indexes and pipeline payload types for the
// ray / cylinder-wall intersection unit. No dependencies.
package rcwi_pkg;

    // Coordinate width and fixed-point layout.
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MIND_W     = 16;
    localparam int DIST_W     = 31;
    localparam int IDX_W      = 3;

    // Derived datapath widths.
    localparam int D_W      = COORD_BITS + 1;        // origin minus centre
    localparam int A_W      = 2 * COORD_BITS;        // a, unsigned
    localparam int B_W      = 2 * COORD_BITS + 2;    // b and the products, signed
    localparam int CR_W     = 2 * COORD_BITS + 3;    // c - r^2, signed
    localparam int PP_W     = 2 * COORD_BITS + 4;    // split partial products, signed
    localparam int SQ_IN_W  = 4 * COORD_BITS + 2;    // discriminant, signed
    localparam int SQ_N     = 2 * COORD_BITS + 1;    // root bits, sqrt stages
    localparam int SQ_REM_W = SQ_N + 3;
    localparam int NUM_W    = 2 * COORD_BITS + 2;    // non-negative numerator
    localparam int DVD_W    = NUM_W + FRAC_BITS;     // dividend and quotient
    localparam int Z_W      = DVD_W + COORD_BITS + 2;

    // Register indexes.
    localparam logic [IDX_W-1:0] CFG_CENTRE_X = 3'd0;
    localparam logic [IDX_W-1:0] CFG_CENTRE_Y = 3'd1;
    localparam logic [IDX_W-1:0] CFG_BASE_Z   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_HEIGHT   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_RADIUS   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_MIN_DIST = 3'd5;

    localparam logic [COORD_BITS-2:0] HEIGHT_RST = (COORD_BITS-1)'(65536);
    localparam logic [COORD_BITS-2:0] RADIUS_RST = (COORD_BITS-1)'(65536);
    localparam logic [MIND_W-1:0]     MIND_RST   = 16'd66;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] centre_x;
        logic signed [COORD_BITS-1:0] centre_y;
        logic signed [COORD_BITS-1:0] base_z;
        logic        [COORD_BITS-2:0] height;
        logic        [COORD_BITS-2:0] radius;
        logic        [MIND_W-1:0]     min_distance;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] origin_x;
        logic signed [COORD_BITS-1:0] origin_y;
        logic signed [COORD_BITS-1:0] origin_z;
        logic signed [COORD_BITS-1:0] dir_x;
        logic signed [COORD_BITS-1:0] dir_y;
        logic signed [COORD_BITS-1:0] dir_z;
    } t_ray;

    // Carried alongside the square root.
    typedef struct packed {
        logic        [A_W-1:0]        a;
        logic signed [B_W-1:0]        b;
        logic signed [COORD_BITS-1:0] oz;
        logic signed [COORD_BITS-1:0] dz;
        logic                         miss;
    } t_sq_side;

    // Carried alongside the two divisions.
    typedef struct packed {
        logic        [A_W-1:0]        a;
        logic signed [COORD_BITS-1:0] oz;
        logic signed [COORD_BITS-1:0] dz;
        logic                         ok_near;
        logic                         ok_far;
    } t_dv_side;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
        logic              leaving;
    } t_res;

endpackage

@@ rtl/core/rcwi_channels.sv @@
// Valid/ready channel interfaces for rays, results and register writes.
// Depends on rcwi_pkg.
interface rcwi_ray_if;
    import rcwi_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic signed [COORD_BITS-1:0] origin_z;
    logic signed [COORD_BITS-1:0] dir_x;
    logic signed [COORD_BITS-1:0] dir_y;
    logic signed [COORD_BITS-1:0] dir_z;
    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

interface rcwi_res_if;
    import rcwi_pkg::*;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [DIST_W-1:0] distance;
    logic              leaving;
    modport source (output valid, hit, distance, leaving, input ready);
    modport sink   (input valid, hit, distance, leaving, output ready);
endinterface

interface rcwi_cfg_if;
    import rcwi_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [IDX_W-1:0]      index;
    logic [COORD_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/ray_cylinder_wall_intersect.sv @@
// Ray / open cylinder wall intersection, top level: register file,
// pipeline control and the channel interfaces. Depends on rcwi_pkg,
// rcwi_channels, rcwi_front, rcwi_sqrt, rcwi_div and rcwi_back.
//
// Usage: rays in the cylinder frame arrive on i_ray, one per transaction.
// Every ray yields exactly one transaction on o_res: hit, distance (Q15.16,
// all ones on a miss or when too far) and leaving (far root taken).
// Registers are written on i_cfg (index and data), always ready; write them
// only while no ray is in flight.
// The pipeline has six front stages for the products, one stage per
// root bit in the square root, one numerator stage plus one stage per
// quotient bit in the two dividers, and three back stages.
// Throughput is one ray per cycle. When o_res is stalled with a result
// waiting, the whole pipeline holds and i_ray.ready drops until the
// result is taken; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults.
module ray_cylinder_wall_intersect (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rcwi_ray_if.sink          i_ray,
    rcwi_cfg_if.sink          i_cfg,
    rcwi_res_if.source        o_res
);
    import rcwi_pkg::*;

    t_cfg             r_cfg;
    t_ray             w_ray;
    logic             w_en;
    logic             w_fv, w_sv, w_dv, w_ov;
    t_sq_side         w_fside, w_sside;
    logic [SQ_IN_W-1:0] w_rad;
    logic [SQ_N-1:0]  w_root;
    t_dv_side         w_dside;
    logic [DVD_W-1:0] w_qn, w_qf;
    t_res             w_res;

    // Register writes.
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.centre_x     <= '0;
            r_cfg.centre_y     <= '0;
            r_cfg.base_z       <= '0;
            r_cfg.height       <= HEIGHT_RST;
            r_cfg.radius       <= RADIUS_RST;
            r_cfg.min_distance <= MIND_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_CENTRE_X: r_cfg.centre_x     <= i_cfg.data;
                CFG_CENTRE_Y: r_cfg.centre_y     <= i_cfg.data;
                CFG_BASE_Z:   r_cfg.base_z       <= i_cfg.data;
                CFG_HEIGHT:   r_cfg.height       <= i_cfg.data[COORD_BITS-2:0];
                CFG_RADIUS:   r_cfg.radius       <= i_cfg.data[COORD_BITS-2:0];
                CFG_MIN_DIST: r_cfg.min_distance <= i_cfg.data[MIND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The pipeline moves unless a finished result is waiting and not taken.
    assign w_en        = !w_ov || o_res.ready;
    assign i_ray.ready = w_en;

    assign w_ray.origin_x = i_ray.origin_x;
    assign w_ray.origin_y = i_ray.origin_y;
    assign w_ray.origin_z = i_ray.origin_z;
    assign w_ray.dir_x    = i_ray.dir_x;
    assign w_ray.dir_y    = i_ray.dir_y;
    assign w_ray.dir_z    = i_ray.dir_z;

    rcwi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_ray.valid),
        .i_ray   (w_ray),
        .i_cfg   (r_cfg),
        .o_valid (w_fv),
        .o_side  (w_fside),
        .o_rad   (w_rad)
    );

    rcwi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_side  (w_fside),
        .i_rad   (w_rad),
        .o_valid (w_sv),
        .o_side  (w_sside),
        .o_root  (w_root)
    );

    rcwi_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_sv),
        .i_side   (w_sside),
        .i_root   (w_root),
        .o_valid  (w_dv),
        .o_side   (w_dside),
        .o_q_near (w_qn),
        .o_q_far  (w_qf)
    );

    rcwi_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_dv),
        .i_side   (w_dside),
        .i_q_near (w_qn),
        .i_q_far  (w_qf),
        .i_cfg    (r_cfg),
        .o_valid  (w_ov),
        .o_res    (w_res)
    );

    assign o_res.valid    = w_ov;
    assign o_res.hit      = w_res.hit;
    assign o_res.distance = w_res.distance;
    assign o_res.leaving  = w_res.leaving;

    // A miss always reports the largest distance and the near side.
    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.hit |-> (o_res.distance == '1) && !o_res.leaving)
        else $error("miss result with unexpected distance or side");

    // A reported hit is never nearer than the minimum distance.
    a_hit_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.hit |-> o_res.distance >= DIST_W'(r_cfg.min_distance))
        else $error("hit nearer than the minimum distance");

    // Input back-pressure only comes from a waiting, stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ray.ready |-> o_res.valid && !o_res.ready)
        else $error("input stalled without a stalled result");

endmodule

@@ rtl/core/rcwi_front.sv @@
// Front end: forms a, b, c - r^2 and the discriminant over six stages.
// Depends on rcwi_pkg.
module rcwi_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  rcwi_pkg::t_ray              i_ray,
    input  rcwi_pkg::t_cfg              i_cfg,
    output logic                        o_valid,
    output rcwi_pkg::t_sq_side          o_side,
    output logic [rcwi_pkg::SQ_IN_W-1:0] o_rad
);
    import rcwi_pkg::*;

    logic [5:0] r_v;

    logic signed [D_W-1:0]        r1_dx, r1_dy;
    logic signed [COORD_BITS-1:0] r1_x, r1_y, r1_oz, r1_dz;

    logic signed [B_W-1:0]        r2_xx, r2_yy, r2_xdx, r2_ydy, r2_dxx, r2_dyy, r2_rr;
    logic signed [COORD_BITS-1:0] r2_oz, r2_dz;

    logic        [A_W-1:0]        r3_a;
    logic signed [B_W-1:0]        r3_b;
    logic signed [CR_W-1:0]       r3_cr;
    logic signed [COORD_BITS-1:0] r3_oz, r3_dz;

    logic signed [PP_W-1:0]       r4_bhh, r4_bhl, r4_bll;
    logic signed [PP_W-1:0]       r4_ahh, r4_ahl, r4_alh, r4_all;
    logic        [A_W-1:0]        r4_a;
    logic signed [B_W-1:0]        r4_b;
    logic signed [COORD_BITS-1:0] r4_oz, r4_dz;
    logic                         r4_azero;

    logic signed [SQ_IN_W-1:0]    r5_bb, r5_acr;
    logic        [A_W-1:0]        r5_a;
    logic signed [B_W-1:0]        r5_b;
    logic signed [COORD_BITS-1:0] r5_oz, r5_dz;
    logic                         r5_azero;

    logic signed [B_W-COORD_BITS-1:0]  n_bh;
    logic signed [CR_W-COORD_BITS-1:0] n_ch;
    logic signed [COORD_BITS:0]        n_bl, n_ah, n_al, n_cl;
    logic signed [SQ_IN_W-1:0]    n_disc;
    logic                         n_miss;
    logic signed [B_W-1:0]        n_a2;

    assign n_a2   = B_W'(r2_xx) + B_W'(r2_yy);

    // Split b, a and c - r^2 into halves for the narrow partial products.
    assign n_bh = r3_b[B_W-1:COORD_BITS];
    assign n_bl = {1'b0, r3_b[COORD_BITS-1:0]};
    assign n_ah = {1'b0, r3_a[A_W-1:COORD_BITS]};
    assign n_al = {1'b0, r3_a[COORD_BITS-1:0]};
    assign n_ch = r3_cr[CR_W-1:COORD_BITS];
    assign n_cl = {1'b0, r3_cr[COORD_BITS-1:0]};

    assign n_disc = r5_bb - r5_acr;
    assign n_miss = r5_azero || n_disc[SQ_IN_W-1];

    // Valid bits advance with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    // Datapath stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx <= D_W'(i_ray.origin_x) - D_W'(i_cfg.centre_x);
            r1_dy <= D_W'(i_ray.origin_y) - D_W'(i_cfg.centre_y);
            r1_x  <= i_ray.dir_x;
            r1_y  <= i_ray.dir_y;
            r1_oz <= i_ray.origin_z;
            r1_dz <= i_ray.dir_z;

            r2_xx  <= B_W'(r1_x) * B_W'(r1_x);
            r2_yy  <= B_W'(r1_y) * B_W'(r1_y);
            r2_xdx <= B_W'(r1_x) * B_W'(r1_dx);
            r2_ydy <= B_W'(r1_y) * B_W'(r1_dy);
            r2_dxx <= B_W'(r1_dx) * B_W'(r1_dx);
            r2_dyy <= B_W'(r1_dy) * B_W'(r1_dy);
            r2_rr  <= B_W'($signed({1'b0, i_cfg.radius})) *
                      B_W'($signed({1'b0, i_cfg.radius}));
            r2_oz  <= r1_oz;
            r2_dz  <= r1_dz;

            r3_a  <= n_a2[A_W-1:0];
            r3_b  <= -(r2_xdx + r2_ydy);
            r3_cr <= CR_W'(r2_dxx) + CR_W'(r2_dyy) - CR_W'(r2_rr);
            r3_oz <= r2_oz;
            r3_dz <= r2_dz;

            // Partial products of b^2 and a * (c - r^2).
            r4_bhh   <= PP_W'(n_bh) * PP_W'(n_bh);
            r4_bhl   <= PP_W'(n_bh) * PP_W'(n_bl);
            r4_bll   <= PP_W'(n_bl) * PP_W'(n_bl);
            r4_ahh   <= PP_W'(n_ah) * PP_W'(n_ch);
            r4_ahl   <= PP_W'(n_ah) * PP_W'(n_cl);
            r4_alh   <= PP_W'(n_al) * PP_W'(n_ch);
            r4_all   <= PP_W'(n_al) * PP_W'(n_cl);
            r4_a     <= r3_a;
            r4_b     <= r3_b;
            r4_oz    <= r3_oz;
            r4_dz    <= r3_dz;
            r4_azero <= (r3_a == '0);

            // Recombine the partial products.
            r5_bb    <= (SQ_IN_W'(r4_bhh) <<< (2 * COORD_BITS)) +
                        (SQ_IN_W'(r4_bhl) <<< (COORD_BITS + 1)) + SQ_IN_W'(r4_bll);
            r5_acr   <= (SQ_IN_W'(r4_ahh) <<< (2 * COORD_BITS)) +
                        ((SQ_IN_W'(r4_ahl) + SQ_IN_W'(r4_alh)) <<< COORD_BITS) +
                        SQ_IN_W'(r4_all);
            r5_a     <= r4_a;
            r5_b     <= r4_b;
            r5_oz    <= r4_oz;
            r5_dz    <= r4_dz;
            r5_azero <= r4_azero;

            o_side.a    <= r5_a;
            o_side.b    <= r5_b;
            o_side.oz   <= r5_oz;
            o_side.dz   <= r5_dz;
            o_side.miss <= n_miss;
            o_rad       <= n_miss ? '0 : n_disc;
        end
    end

    assign o_valid = r_v[5];

endmodule

@@ rtl/core/rcwi_sqrt.sv @@
// Pipelined floor square root, one root bit per stage, with sideband.
// Depends on rcwi_pkg.
module rcwi_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  rcwi_pkg::t_sq_side           i_side,
    input  logic [rcwi_pkg::SQ_IN_W-1:0] i_rad,
    output logic                         o_valid,
    output rcwi_pkg::t_sq_side           o_side,
    output logic [rcwi_pkg::SQ_N-1:0]    o_root
);
    import rcwi_pkg::*;

    logic [SQ_N-1:0]     r_v;
    logic [SQ_IN_W-1:0]  r_rad  [SQ_N];
    logic [SQ_REM_W-1:0] r_rem  [SQ_N];
    logic [SQ_N-1:0]     r_root [SQ_N];
    t_sq_side            r_side [SQ_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[SQ_N-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < SQ_N; k++) begin : g_stage
        logic [SQ_IN_W-1:0]  rad_in;
        logic [SQ_REM_W-1:0] rem_in, rem_s, trial;
        logic [SQ_N-1:0]     root_in;
        t_sq_side            side_in;
        logic                ge;

        if (k == 0) begin : g_first
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
        end

        // Bring down two radicand bits and try the next root bit.
        assign rem_s = {rem_in[SQ_REM_W-3:0], rad_in[SQ_IN_W-1 -: 2]};
        assign trial = SQ_REM_W'({root_in, 2'b01});
        assign ge    = (rem_s >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= {rad_in[SQ_IN_W-3:0], 2'b00};
                r_rem[k]  <= ge ? (rem_s - trial) : rem_s;
                r_root[k] <= {root_in[SQ_N-2:0], ge};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[SQ_N-1];
    assign o_side  = r_side[SQ_N-1];
    assign o_root  = r_root[SQ_N-1];

endmodule

@@ rtl/core/rcwi_div.sv @@
// Forms both root numerators and divides them by a in two restoring
// pipelines, one quotient bit per stage. Depends on rcwi_pkg.
module rcwi_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  rcwi_pkg::t_sq_side         i_side,
    input  logic [rcwi_pkg::SQ_N-1:0]  i_root,
    output logic                       o_valid,
    output rcwi_pkg::t_dv_side         o_side,
    output logic [rcwi_pkg::DVD_W-1:0] o_q_near,
    output logic [rcwi_pkg::DVD_W-1:0] o_q_far
);
    import rcwi_pkg::*;

    logic                  r0_v;
    logic [DVD_W-1:0]      r0_dn, r0_df;
    t_dv_side              r0_side;
    logic signed [NUM_W:0] n_num_n, n_num_f;

    logic [DVD_W-1:0] r_v;
    logic [DVD_W-1:0] r_dn   [DVD_W];
    logic [DVD_W-1:0] r_df   [DVD_W];
    logic [A_W-1:0]   r_remn [DVD_W];
    logic [A_W-1:0]   r_remf [DVD_W];
    t_dv_side         r_side [DVD_W];

    // Near and far numerators; a negative one is cleared and marks its root unusable.
    assign n_num_n = (NUM_W+1)'(i_side.b) - (NUM_W+1)'($signed({1'b0, i_root}));
    assign n_num_f = (NUM_W+1)'(i_side.b) + (NUM_W+1)'($signed({1'b0, i_root}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r_v  <= '0;
        end else if (i_en) begin
            r0_v <= i_valid;
            r_v  <= {r_v[DVD_W-2:0], r0_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_dn           <= n_num_n[NUM_W] ? '0 : {n_num_n[NUM_W-1:0], FRAC_BITS'(0)};
            r0_df           <= n_num_f[NUM_W] ? '0 : {n_num_f[NUM_W-1:0], FRAC_BITS'(0)};
            r0_side.a       <= i_side.a;
            r0_side.oz      <= i_side.oz;
            r0_side.dz      <= i_side.dz;
            r0_side.ok_near <= !i_side.miss && !n_num_n[NUM_W];
            r0_side.ok_far  <= !i_side.miss && !n_num_f[NUM_W];
        end
    end

    for (genvar k = 0; k < DVD_W; k++) begin : g_stage
        logic [DVD_W-1:0] dn_in, df_in;
        logic [A_W-1:0]   remn_in, remf_in;
        logic [A_W:0]     sn, sf;
        t_dv_side         side_in;
        logic             gen, gef;

        if (k == 0) begin : g_first
            assign dn_in   = r0_dn;
            assign df_in   = r0_df;
            assign remn_in = '0;
            assign remf_in = '0;
            assign side_in = r0_side;
        end else begin : g_next
            assign dn_in   = r_dn[k-1];
            assign df_in   = r_df[k-1];
            assign remn_in = r_remn[k-1];
            assign remf_in = r_remf[k-1];
            assign side_in = r_side[k-1];
        end

        // Shift in the next dividend bit and subtract the divisor if it fits.
        assign sn  = {remn_in, dn_in[DVD_W-1]};
        assign sf  = {remf_in, df_in[DVD_W-1]};
        assign gen = (sn >= {1'b0, side_in.a});
        assign gef = (sf >= {1'b0, side_in.a});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dn[k]   <= {dn_in[DVD_W-2:0], gen};
                r_df[k]   <= {df_in[DVD_W-2:0], gef};
                r_remn[k] <= gen ? A_W'(sn - {1'b0, side_in.a}) : A_W'(sn);
                r_remf[k] <= gef ? A_W'(sf - {1'b0, side_in.a}) : A_W'(sf);
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid  = r_v[DVD_W-1];
    assign o_side   = r_side[DVD_W-1];
    assign o_q_near = r_dn[DVD_W-1];
    assign o_q_far  = r_df[DVD_W-1];

endmodule

@@ rtl/core/rcwi_back.sv @@
// Back end: wall height test for both roots, root selection and the
// result register. Depends on rcwi_pkg.
module rcwi_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  rcwi_pkg::t_dv_side         i_side,
    input  logic [rcwi_pkg::DVD_W-1:0] i_q_near,
    input  logic [rcwi_pkg::DVD_W-1:0] i_q_far,
    input  rcwi_pkg::t_cfg             i_cfg,
    output logic                       o_valid,
    output rcwi_pkg::t_res             o_res
);
    import rcwi_pkg::*;

    logic                         r1_v, r2_v;
    logic signed [B_W-1:0]        r1_pn0, r1_pn1, r1_pn2, r1_pf0, r1_pf1, r1_pf2;
    logic [DVD_W-1:0]             r1_qn, r1_qf, r2_qn, r2_qf;
    logic                         r1_okn, r1_okf, r2_okn, r2_okf;
    logic signed [COORD_BITS-1:0] r1_oz, r2_oz;
    logic signed [Z_W-1:0]        r2_pn, r2_pf;

    logic signed [Z_W-1:0] n_oz, n_zn, n_zf, n_lo, n_hi;
    logic                  n_hitn, n_hitf;
    logic [DVD_W-1:0]      n_q;

    // Wall point z for each root, compared with the open height range.
    assign n_oz   = Z_W'(r2_oz) <<< FRAC_BITS;
    assign n_zn   = n_oz + r2_pn;
    assign n_zf   = n_oz + r2_pf;
    assign n_lo   = Z_W'(i_cfg.base_z) <<< FRAC_BITS;
    assign n_hi   = (Z_W'(i_cfg.base_z) + Z_W'($signed({1'b0, i_cfg.height}))) <<< FRAC_BITS;
    assign n_hitn = r2_okn && (n_zn > n_lo) && (n_zn < n_hi);
    assign n_hitf = r2_okf && (n_zf > n_lo) && (n_zf < n_hi);
    assign n_q    = n_hitn ? r2_qn : r2_qf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            o_valid <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Quotient times dir_z, formed as one product per slice of the quotient.
            r1_pn0 <= B_W'($signed({1'b0, i_q_near[COORD_BITS-1:0]})) * B_W'(i_side.dz);
            r1_pn1 <= B_W'($signed({1'b0, i_q_near[2*COORD_BITS-1:COORD_BITS]})) *
                      B_W'(i_side.dz);
            r1_pn2 <= B_W'($signed({1'b0, i_q_near[DVD_W-1:2*COORD_BITS]})) *
                      B_W'(i_side.dz);
            r1_pf0 <= B_W'($signed({1'b0, i_q_far[COORD_BITS-1:0]})) * B_W'(i_side.dz);
            r1_pf1 <= B_W'($signed({1'b0, i_q_far[2*COORD_BITS-1:COORD_BITS]})) *
                      B_W'(i_side.dz);
            r1_pf2 <= B_W'($signed({1'b0, i_q_far[DVD_W-1:2*COORD_BITS]})) *
                      B_W'(i_side.dz);
            r1_qn  <= i_q_near;
            r1_qf  <= i_q_far;
            r1_okn <= i_side.ok_near && (i_q_near >= DVD_W'(i_cfg.min_distance));
            r1_okf <= i_side.ok_far && (i_q_far >= DVD_W'(i_cfg.min_distance));
            r1_oz  <= i_side.oz;

            // Recombine the slices into the full products.
            r2_pn  <= Z_W'(r1_pn0) + (Z_W'(r1_pn1) <<< COORD_BITS) +
                      (Z_W'(r1_pn2) <<< (2 * COORD_BITS));
            r2_pf  <= Z_W'(r1_pf0) + (Z_W'(r1_pf1) <<< COORD_BITS) +
                      (Z_W'(r1_pf2) <<< (2 * COORD_BITS));
            r2_qn  <= r1_qn;
            r2_qf  <= r1_qf;
            r2_okn <= r1_okn;
            r2_okf <= r1_okf;
            r2_oz  <= r1_oz;

            // Near root wins; a miss or an out-of-range distance reports the largest distance.
            o_res.hit      <= n_hitn || n_hitf;
            o_res.leaving  <= !n_hitn && n_hitf;
            if (!(n_hitn || n_hitf) || (|n_q[DVD_W-1:DIST_W])) begin
                o_res.distance <= '1;
            end else begin
                o_res.distance <= n_q[DIST_W-1:0];
            end
        end
    end

endmodule
